// File: rtl/core/sfe_pkg.sv
// shared constants, register codes and types of the smoothstep fade envelope unit
package sfe_pkg;

   // fixed field widths
   localparam int TIME_W     = 32;
   localparam int REG_W      = 31;
   localparam int ENV_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIFE_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT_WIDTH = 2'd2;

   // per-request status carried down the pipeline
   typedef struct packed {
      logic alive;
      logic in_full;
      logic out_full;
   } sfe_flags_type;

   // divider operands of both ramps
   typedef struct packed {
      logic [REG_W-1:0] rem_in;
      logic [REG_W-1:0] w_in;
      logic [REG_W-1:0] rem_out;
      logic [REG_W-1:0] w_out;
   } sfe_div_type;

endpackage

// File: rtl/core/sfe_ifs.sv
// request, response and register-write channel interfaces

interface sfe_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [sfe_pkg::TIME_W-1:0]       local_time;
   logic        [sfe_pkg::REG_W-1:0]        window_length;
   logic                                    window_unbounded;

   modport source (output valid, local_time, window_length, window_unbounded, input ready);
   modport sink   (input valid, local_time, window_length, window_unbounded, output ready);
endinterface

interface sfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sfe_pkg::ENV_W-1:0]    envelope;
   logic                         alive;

   modport source (output valid, envelope, alive, input ready);
   modport sink   (input valid, envelope, alive, output ready);
endinterface

interface sfe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sfe_pkg::CSR_IDX_W-1:0]     index;
   logic [sfe_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/sfe_front.sv
// front stage: lifetime selection, range checks and divider operand setup
module sfe_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   sfe_req_if.sink                       req,
   input  logic [sfe_pkg::REG_W-1:0]     life_length,
   input  logic [sfe_pkg::REG_W-1:0]     fade_in_width,
   input  logic [sfe_pkg::REG_W-1:0]     fade_out_width,
   output logic                          out_valid,
   input  logic                          out_ready,
   output sfe_pkg::sfe_flags_type        out_flags,
   output sfe_pkg::sfe_div_type          out_div
);

   localparam int CW = (TIME_BITS - 1 > sfe_pkg::REG_W) ? TIME_BITS - 1 : sfe_pkg::REG_W;

   logic [TIME_BITS+sfe_pkg::TIME_W-1:0] time_ext;
   logic [TIME_BITS-1:0]                 local_bits;
   logic                                 negative;
   logic [CW-1:0]                        mag;
   logic [sfe_pkg::REG_W-1:0]            life;
   logic                                 bounded;
   logic [sfe_pkg::REG_W-1:0]            out_x;

   logic                                 valid_ff, valid_in;
   sfe_pkg::sfe_flags_type               flags_ff, flags_in;
   sfe_pkg::sfe_div_type                 div_ff, div_in;

   // time read as a TIME_BITS-bit signed value
   assign time_ext   = {{TIME_BITS{1'b0}}, req.local_time};
   assign local_bits = time_ext[TIME_BITS-1:0];
   assign negative   = local_bits[TIME_BITS-1];
   assign mag        = CW'(local_bits[TIME_BITS-2:0]);

   // lifetime and ramp classification
   always_comb begin
      if (life_length != '0) begin
         life    = life_length;
         bounded = 1'b1;
      end else begin
         life    = req.window_length;
         bounded = !req.window_unbounded;
      end
      out_x = life - mag[sfe_pkg::REG_W-1:0];

      flags_in.alive    = !negative && !(bounded && (mag >= CW'(life)));
      flags_in.in_full  = (fade_in_width == '0) || (mag >= CW'(fade_in_width));
      flags_in.out_full = (fade_out_width == '0) || !bounded || (out_x >= fade_out_width);

      div_in.rem_in  = mag[sfe_pkg::REG_W-1:0];
      div_in.w_in    = fade_in_width;
      div_in.rem_out = out_x;
      div_in.w_out   = fade_out_width;
   end

   // stage handshake
   assign req.ready = !valid_ff || out_ready;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         flags_ff <= flags_in;
         div_ff   <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_div   = div_ff;

endmodule

// File: rtl/core/sfe_div_cell.sv
// divider cell: one restoring quotient bit for each of the two ramps
module sfe_div_cell #(
   parameter int FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sfe_pkg::sfe_flags_type        in_flags,
   input  sfe_pkg::sfe_div_type          in_div,
   input  logic [FRAC_BITS-1:0]          in_q_in,
   input  logic [FRAC_BITS-1:0]          in_q_out,
   output logic                          out_valid,
   input  logic                          out_ready,
   output sfe_pkg::sfe_flags_type        out_flags,
   output sfe_pkg::sfe_div_type          out_div,
   output logic [FRAC_BITS-1:0]          out_q_in,
   output logic [FRAC_BITS-1:0]          out_q_out
);

   logic [sfe_pkg::REG_W:0]     shift_in, shift_out;
   logic                        ge_in, ge_out;
   logic [sfe_pkg::REG_W:0]     diff_in, diff_out;

   logic                        valid_ff, valid_in;
   sfe_pkg::sfe_flags_type      flags_ff;
   sfe_pkg::sfe_div_type        div_ff, div_in;
   logic [FRAC_BITS-1:0]        q_in_ff, q_in_in;
   logic [FRAC_BITS-1:0]        q_out_ff, q_out_in;

   // shift, compare and conditional subtract on both lanes
   always_comb begin
      shift_in  = {in_div.rem_in, 1'b0};
      shift_out = {in_div.rem_out, 1'b0};
      ge_in     = shift_in >= {1'b0, in_div.w_in};
      ge_out    = shift_out >= {1'b0, in_div.w_out};
      diff_in   = shift_in - {1'b0, in_div.w_in};
      diff_out  = shift_out - {1'b0, in_div.w_out};

      div_in         = in_div;
      div_in.rem_in  = ge_in  ? diff_in[sfe_pkg::REG_W-1:0]  : shift_in[sfe_pkg::REG_W-1:0];
      div_in.rem_out = ge_out ? diff_out[sfe_pkg::REG_W-1:0] : shift_out[sfe_pkg::REG_W-1:0];
      q_in_in        = {in_q_in[FRAC_BITS-2:0], ge_in};
      q_out_in       = {in_q_out[FRAC_BITS-2:0], ge_out};
   end

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flags_ff <= in_flags;
         div_ff   <= div_in;
         q_in_ff  <= q_in_in;
         q_out_ff <= q_out_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_div   = div_ff;
   assign out_q_in  = q_in_ff;
   assign out_q_out = q_out_ff;

endmodule

// File: rtl/core/sfe_poly.sv
// cubic back end: square, smoothstep cubic and ramp product, ending in the output register
module sfe_poly #(
   parameter int FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sfe_pkg::sfe_flags_type        in_flags,
   input  logic [FRAC_BITS-1:0]          in_t_in,
   input  logic [FRAC_BITS-1:0]          in_t_out,
   sfe_rsp_if.source                     rsp
);

   localparam int PW = (FRAC_BITS + 1 > sfe_pkg::ENV_W) ? FRAC_BITS + 1 : sfe_pkg::ENV_W;
   localparam logic [FRAC_BITS:0]   ONE       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS+1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

   // square stage
   logic                        a_valid_ff, a_valid_in, a_ready;
   sfe_pkg::sfe_flags_type      a_flags_ff;
   logic [FRAC_BITS-1:0]        a_t_in_ff, a_t_out_ff;
   logic [FRAC_BITS-1:0]        a_s_in_ff, a_s_out_ff, a_s_in_in, a_s_out_in;
   logic [2*FRAC_BITS-1:0]      sq_in, sq_out;

   // cubic stage
   logic                        b_valid_ff, b_valid_in, b_ready;
   logic                        b_alive_ff;
   logic [FRAC_BITS:0]          b_r_in_ff, b_r_out_ff, b_r_in_in, b_r_out_in;
   logic [FRAC_BITS+1:0]        poly_in, poly_out;
   logic [2*FRAC_BITS+1:0]      cub_in, cub_out;

   // combine stage, the output register
   logic                        c_valid_ff, c_valid_in, c_ready;
   logic                        c_alive_ff;
   logic [FRAC_BITS:0]          c_env_ff, c_env_in;
   logic [2*FRAC_BITS+1:0]      prod;
   logic [PW-1:0]               env_wide;

   // ready cascade
   assign c_ready  = !c_valid_ff || rsp.ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // t squared
   always_comb begin
      sq_in      = in_t_in * in_t_in;
      sq_out     = in_t_out * in_t_out;
      a_s_in_in  = sq_in[2*FRAC_BITS-1:FRAC_BITS];
      a_s_out_in = sq_out[2*FRAC_BITS-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_flags_ff <= in_flags;
         a_t_in_ff  <= in_t_in;
         a_t_out_ff <= in_t_out;
         a_s_in_ff  <= a_s_in_in;
         a_s_out_ff <= a_s_out_in;
      end
   end

   // s times (3 - 2t), full ramps forced to one
   always_comb begin
      poly_in    = THREE_ONE - {1'b0, a_t_in_ff, 1'b0};
      poly_out   = THREE_ONE - {1'b0, a_t_out_ff, 1'b0};
      cub_in     = a_s_in_ff * poly_in;
      cub_out    = a_s_out_ff * poly_out;
      b_r_in_in  = a_flags_ff.in_full  ? ONE : cub_in[2*FRAC_BITS:FRAC_BITS];
      b_r_out_in = a_flags_ff.out_full ? ONE : cub_out[2*FRAC_BITS:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_alive_ff <= a_flags_ff.alive;
         b_r_in_ff  <= b_r_in_in;
         b_r_out_ff <= b_r_out_in;
      end
   end

   // product of both ramps, zero when not alive
   always_comb begin
      prod     = b_r_in_ff * b_r_out_ff;
      c_env_in = b_alive_ff ? prod[2*FRAC_BITS:FRAC_BITS] : '0;
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && c_ready) begin
         c_alive_ff <= b_alive_ff;
         c_env_ff   <= c_env_in;
      end
   end

   // response, envelope kept to its low 16 bits
   assign env_wide     = PW'(c_env_ff);
   assign rsp.valid    = c_valid_ff;
   assign rsp.envelope = env_wide[sfe_pkg::ENV_W-1:0];
   assign rsp.alive    = c_alive_ff;

endmodule

// File: rtl/core/smoothstep_fade_envelope_unit.sv
// top level of the smoothstep fade envelope unit
//
//   channel  port    dir  payload
//   -------  ------  ---  ------------------------------------------
//   request  req_ch  in   local_time, window_length, window_unbounded
//   result   rsp_ch  out  envelope, alive
//   config   csr_ch  in   index, data
//
// one request per cycle unless the result side stalls; the pipeline is the front stage,
// the chain of divider cells (one quotient bit each) and three cubic stages.
// synchronous reset clears valid bits and the three registers.
// every stage has its own valid bit, so bubbles close up when the result side stalls.
// register writes are always taken.
module smoothstep_fade_envelope_unit #(
   parameter int TIME_BITS          = 32,
   parameter int ENVELOPE_FRAC_BITS = 15
) (
   input  logic       clock,
   input  logic       reset,
   sfe_req_if.sink    req_ch,
   sfe_rsp_if.source  rsp_ch,
   sfe_csr_if.sink    csr_ch
);

   localparam int F = ENVELOPE_FRAC_BITS;

   logic [sfe_pkg::REG_W-1:0]   life_ff, life_in;
   logic [sfe_pkg::REG_W-1:0]   fin_ff, fin_in;
   logic [sfe_pkg::REG_W-1:0]   fout_ff, fout_in;

   // link k is the output of stage k (front is stage 0)
   logic                        link_valid [0:F];
   logic                        link_ready [0:F];
   sfe_pkg::sfe_flags_type      link_flags [0:F];
   sfe_pkg::sfe_div_type        link_div   [0:F];
   logic [F-1:0]                link_q_in  [0:F];
   logic [F-1:0]                link_q_out [0:F];

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      life_in = life_ff;
      fin_in  = fin_ff;
      fout_in = fout_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            sfe_pkg::CSR_LIFE_LENGTH:    life_in = csr_ch.data[sfe_pkg::REG_W-1:0];
            sfe_pkg::CSR_FADE_IN_WIDTH:  fin_in  = csr_ch.data[sfe_pkg::REG_W-1:0];
            sfe_pkg::CSR_FADE_OUT_WIDTH: fout_in = csr_ch.data[sfe_pkg::REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff <= '0;
         fin_ff  <= '0;
         fout_ff <= '0;
      end else begin
         life_ff <= life_in;
         fin_ff  <= fin_in;
         fout_ff <= fout_in;
      end
   end

   // front stage
   sfe_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .life_length    (life_ff),
      .fade_in_width  (fin_ff),
      .fade_out_width (fout_ff),
      .out_valid      (link_valid[0]),
      .out_ready      (link_ready[0]),
      .out_flags      (link_flags[0]),
      .out_div        (link_div[0])
   );

   assign link_q_in[0]  = '0;
   assign link_q_out[0] = '0;

   // chain of divider cells
   for (genvar k = 1; k <= F; k++) begin : g_cell
      sfe_div_cell #(
         .FRAC_BITS (F)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k-1]),
         .in_ready  (link_ready[k-1]),
         .in_flags  (link_flags[k-1]),
         .in_div    (link_div[k-1]),
         .in_q_in   (link_q_in[k-1]),
         .in_q_out  (link_q_out[k-1]),
         .out_valid (link_valid[k]),
         .out_ready (link_ready[k]),
         .out_flags (link_flags[k]),
         .out_div   (link_div[k]),
         .out_q_in  (link_q_in[k]),
         .out_q_out (link_q_out[k])
      );
   end

   // cubic back end and output register
   sfe_poly #(
      .FRAC_BITS (F)
   ) u_poly (
      .clock    (clock),
      .reset    (reset),
      .in_valid (link_valid[F]),
      .in_ready (link_ready[F]),
      .in_flags (link_flags[F]),
      .in_t_in  (link_q_in[F]),
      .in_t_out (link_q_out[F]),
      .rsp      (rsp_ch)
   );

   // a dead result carries a zero envelope
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.alive |-> rsp_ch.envelope == '0)
      else $error("dead result with nonzero envelope");

   // an accepted request lands in the front stage
   a_front_load: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> link_valid[0])
      else $error("accepted request lost at front stage");

   // fade-in divider starts with remainder below divisor
   a_div_in_range: assert property (@(posedge clock) disable iff (reset)
      link_valid[0] && link_flags[0].alive && !link_flags[0].in_full
         |-> link_div[0].rem_in < link_div[0].w_in)
      else $error("fade-in dividend out of range");

   // fade-out divider starts with remainder below divisor
   a_div_out_range: assert property (@(posedge clock) disable iff (reset)
      link_valid[0] && link_flags[0].alive && !link_flags[0].out_full
         |-> link_div[0].rem_out < link_div[0].w_out)
      else $error("fade-out dividend out of range");

endmodule
